// File: design/psf_pkg.sv
// Shared types and default constants for the prime sieve filter.
package psf_pkg;

   // Default table depth and candidate width.
   localparam int MAX_PRIMES_DEF = 64;
   localparam int VALUE_BITS_DEF = 16;

   // Sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_REDUCE,
      ST_DECIDE
   } state_type;

   // Control broadcast from the sequencer to every cell of the chain.
   typedef struct packed {
      logic start;     // clear the partial remainder
      logic step;      // take one candidate bit into the remainder
      logic cand_bit;  // candidate bit, most significant first
      logic push;      // shift the table one cell down the chain
   } cell_ctrl_type;

endpackage

// File: design/psf_cell.sv
// One table cell: holds a prime and runs a bit-serial remainder check against it.
module psf_cell #(
   parameter int VALUE_BITS = psf_pkg::VALUE_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  psf_pkg::cell_ctrl_type ctrl,
   input  logic                   prev_valid,
   input  logic [VALUE_BITS-1:0]  prev_value,
   output logic                   valid,
   output logic [VALUE_BITS-1:0]  value,
   output logic                   hit
);
   import psf_pkg::*;

   logic                  valid_ff;
   logic [VALUE_BITS-1:0] value_ff;
   logic [VALUE_BITS-1:0] rem_ff;
   logic [VALUE_BITS-1:0] rem_in;
   logic [VALUE_BITS:0]   trial;
   logic [VALUE_BITS:0]   divisor;
   logic [VALUE_BITS:0]   diff;

   // Restoring remainder step: shift in one candidate bit, subtract if it fits.
   always_comb begin
      trial   = {rem_ff, ctrl.cand_bit};
      divisor = {1'b0, value_ff};
      diff    = trial - divisor;
      if (trial >= divisor) begin
         rem_in = diff[VALUE_BITS-1:0];
      end else begin
         rem_in = trial[VALUE_BITS-1:0];
      end
   end

   // Occupancy moves down the chain when a new prime is pushed in.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctrl.push) begin
         valid_ff <= prev_valid;
      end
   end

   // Stored prime and partial remainder.
   always_ff @(posedge clock) begin
      if (ctrl.push) begin
         value_ff <= prev_value;
      end
      if (ctrl.start) begin
         rem_ff <= '0;
      end else if (ctrl.step) begin
         rem_ff <= rem_in;
      end
   end

   assign valid = valid_ff;
   assign value = value_ff;
   assign hit   = valid_ff && (rem_ff == '0);

endmodule

// File: design/psf_ctrl.sv
// Sequencer: takes requests, steps the cell chain and holds the result register.
module psf_ctrl #(
   parameter int MAX_PRIMES = psf_pkg::MAX_PRIMES_DEF,
   parameter int VALUE_BITS = psf_pkg::VALUE_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [((VALUE_BITS+7)/8)*8-1:0]     req_tdata,   // candidate
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [((VALUE_BITS+7)/8)*8-1:0]     rsp_tdata,   // prime_value
   output logic                                rsp_tuser,   // was_stored
   input  logic [MAX_PRIMES-1:0]               hits,
   input  logic                                full,
   output psf_pkg::cell_ctrl_type              ctrl,
   output logic [VALUE_BITS-1:0]               push_value
);
   import psf_pkg::*;

   localparam int DATA_W = ((VALUE_BITS + 7) / 8) * 8;
   localparam int STEP_W = $clog2(VALUE_BITS);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(VALUE_BITS - 1);

   state_type             state_ff, state_in;
   logic [VALUE_BITS-1:0] cand_ff, cand_in;
   logic [VALUE_BITS-1:0] shift_ff, shift_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic                  hit_ff, hit_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [VALUE_BITS-1:0] rsp_data_ff, rsp_data_in;
   logic                  rsp_stored_ff, rsp_stored_in;
   logic [VALUE_BITS-1:0] req_cand;
   logic                  out_free;

   assign req_cand = req_tdata[VALUE_BITS-1:0];
   assign out_free = !rsp_valid_ff || rsp_tready;

   // State register and control flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working registers.
   always_ff @(posedge clock) begin
      cand_ff       <= cand_in;
      shift_ff      <= shift_in;
      step_ff       <= step_in;
      hit_ff        <= hit_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_stored_ff <= rsp_stored_in;
   end

   // Next state, chain control and result loading.
   always_comb begin
      state_in      = state_ff;
      cand_in       = cand_ff;
      shift_in      = shift_ff;
      step_in       = step_ff;
      hit_in        = hit_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_stored_in = rsp_stored_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      req_tready    = 1'b0;
      ctrl          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            // Zero and one are not prime and are dropped at once.
            if (req_tvalid && (req_cand >= VALUE_BITS'(2))) begin
               cand_in    = req_cand;
               shift_in   = req_cand;
               step_in    = '0;
               ctrl.start = 1'b1;
               state_in   = ST_RUN;
            end
         end
         ST_RUN: begin
            ctrl.step     = 1'b1;
            ctrl.cand_bit = shift_ff[VALUE_BITS-1];
            shift_in      = {shift_ff[VALUE_BITS-2:0], 1'b0};
            step_in       = step_ff + STEP_W'(1);
            if (step_ff == LAST_STEP) begin
               state_in = ST_REDUCE;
            end
         end
         ST_REDUCE: begin
            hit_in   = |hits;
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (hit_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               ctrl.push     = !full;
               rsp_data_in   = cand_ff;
               rsp_stored_in = !full;
               rsp_valid_in  = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign push_value = cand_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = DATA_W'(rsp_data_ff);
   assign rsp_tuser  = rsp_stored_ff;

`ifndef SYNTH
   // A test that needs the chain keeps the input closed on the next cycle.
   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && req_tvalid && req_cand >= VALUE_BITS'(2))
      |=> !req_tready)
      else $error("request taken while the chain is busy");

   // A result only appears out of the decision step.
   a_rsp_from_decide: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff) == ST_DECIDE)
      else $error("result raised outside the decision step");

   // The bit counter never runs past the candidate width.
   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> (step_ff <= LAST_STEP))
      else $error("remainder step counter overran");

   // A prime flagged as stored is never reported while the table was full.
   a_no_store_when_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DECIDE && !hit_ff && out_free && full) |=> !rsp_tuser)
      else $error("prime flagged as stored into a full table");
`endif

endmodule

// File: design/prime_sieve_filter.sv
// Top level of the prime sieve filter: sequencer plus a chain of prime cells.
//
// Usage: candidates arrive on the req_ channel (req_tdata holds the candidate),
// normally counting up from 2. Each candidate is tested against every prime
// held in the cell chain; if none divides it, it is sent on the rsp_ channel
// (rsp_tdata holds the prime, rsp_tuser is set when it was added to the table)
// and pushed into the head of the chain. A divisible candidate gives nothing.
// Once all MAX_PRIMES cells are filled, primes still go out with rsp_tuser low
// and later results may name composites as primes.
// Timing: all cells check in parallel, one quotient bit per cycle; after the
// last bit the hits are reduced and then decided, and a prime is written to
// the result register. The next request is taken only after that decision,
// divisible or not, so one candidate is tested at a time. Zero and one are
// dropped in the cycle they are accepted.
// Reset empties the table and drops any pending result. When the receiver
// stalls, the result waits in its register while the next request is tested;
// a further prime then waits in the decision step until the register frees.
module prime_sieve_filter #(
   parameter int MAX_PRIMES = psf_pkg::MAX_PRIMES_DEF,
   parameter int VALUE_BITS = psf_pkg::VALUE_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [((VALUE_BITS+7)/8)*8-1:0] req_tdata,   // candidate
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [((VALUE_BITS+7)/8)*8-1:0] rsp_tdata,   // prime_value
   output logic                            rsp_tuser    // was_stored
);
   import psf_pkg::*;

   cell_ctrl_type         ctrl;
   logic [VALUE_BITS-1:0] push_value;
   logic [MAX_PRIMES-1:0] hits;
   logic [MAX_PRIMES-1:0] cell_valid;
   logic [VALUE_BITS-1:0] cell_value [MAX_PRIMES];

   psf_ctrl #(
      .MAX_PRIMES (MAX_PRIMES),
      .VALUE_BITS (VALUE_BITS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .hits       (hits),
      .full       (cell_valid[MAX_PRIMES-1]),
      .ctrl       (ctrl),
      .push_value (push_value)
   );

   // Cell chain: a new prime enters cell zero and older ones move one cell down.
   for (genvar i = 0; i < MAX_PRIMES; i++) begin : g_cell
      if (i == 0) begin : g_head
         psf_cell #(
            .VALUE_BITS (VALUE_BITS)
         ) u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctrl       (ctrl),
            .prev_valid (1'b1),
            .prev_value (push_value),
            .valid      (cell_valid[i]),
            .value      (cell_value[i]),
            .hit        (hits[i])
         );
      end else begin : g_body
         psf_cell #(
            .VALUE_BITS (VALUE_BITS)
         ) u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctrl       (ctrl),
            .prev_valid (cell_valid[i-1]),
            .prev_value (cell_value[i-1]),
            .valid      (cell_valid[i]),
            .value      (cell_value[i]),
            .hit        (hits[i])
         );
      end
   end

endmodule

// File: tb/tb.sv
// Self-checking testbench for the prime sieve filter: trial-division predictor and stream checks.
`timescale 1ns / 100ps

module tb;

   localparam int TABLE_DEPTH = psf_pkg::MAX_PRIMES_DEF;
   localparam int VBITS       = psf_pkg::VALUE_BITS_DEF;
   localparam int DATA_W      = ((VBITS + 7) / 8) * 8;
   localparam int BLOCK_CYCLES = VBITS + 3;
   localparam int DRAIN_LIMIT  = 4000;
   localparam int HOLD_CYCLES  = 300;
   localparam int RANDOM_ITEMS = 950;

   // One prime expected on the response channel.
   typedef struct packed {
      logic [VBITS-1:0] prime_value;
      logic             was_stored;
   } prime_result_type;

   logic              clock      = 1'b0;
   logic              reset      = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [DATA_W-1:0] req_tdata  = '0;   // candidate
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [DATA_W-1:0] rsp_tdata;         // prime_value
   logic              rsp_tuser;         // was_stored

   // Predictor state: the primes the block should hold so far.
   logic [VBITS-1:0] sieve_table [TABLE_DEPTH];
   int unsigned      sieve_count = 0;
   prime_result_type expected_primes[$];

   // Stimulus and receiver controls.
   int unsigned gap_max        = 0;
   int unsigned stall_max      = 0;
   int unsigned stall_left     = 0;
   bit          result_waiting = 1'b0;
   bit          hold_results   = 1'b0;
   int unsigned next_count     = 2;

   // Run statistics.
   int unsigned failures       = 0;
   int unsigned requests_sent  = 0;
   int unsigned primes_checked = 0;
   int unsigned stored_checked = 0;

   prime_sieve_filter dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // Free-running clock.
   initial begin
      forever #10 clock = ~clock;
   end

   // Watchdog for a hung run.
   initial begin
      #10_000_000;
      $display("Timeout: %0d primes still pending at %0t", expected_primes.size(), $time);
      $display("Regression FAIL");
      $finish;
   end

   function automatic void note_failure(input string msg);
      failures++;
      if (failures <= 10)
         $display("Mismatch at %0t: %s", $time, msg);
   endfunction

   // Trial division against the primes stored so far; queues the prime if one results.
   function automatic void predict_candidate(input logic [VBITS-1:0] cand);
      bit               divisible;
      prime_result_type res;
      int unsigned      i;
      divisible = 1'b0;
      if (cand < 2)
         return;
      for (i = 0; i < sieve_count; i++)
         if (cand % sieve_table[i] == 0)
            divisible = 1'b1;
      if (divisible)
         return;
      res.prime_value = cand;
      res.was_stored  = (sieve_count < TABLE_DEPTH);
      if (res.was_stored) begin
         sieve_table[sieve_count] = cand;
         sieve_count++;
      end
      expected_primes.push_back(res);
   endfunction

   // Compares one accepted response with the oldest pending prime.
   function automatic void check_prime(input logic [DATA_W-1:0] data, input logic user);
      prime_result_type want;
      if (expected_primes.size() == 0) begin
         note_failure($sformatf("unexpected prime %0d (stored %b)", data, user));
         return;
      end
      want = expected_primes.pop_front();
      if (data !== DATA_W'(want.prime_value))
         note_failure($sformatf("prime_value expected %0d, got %0d", want.prime_value, data));
      if (user !== want.was_stored)
         note_failure($sformatf("was_stored for %0d expected %b, got %b",
                                want.prime_value, want.was_stored, user));
      primes_checked++;
      if (want.was_stored)
         stored_checked++;
   endfunction

   // Response monitor: checks each accepted prime and draws the next stall.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         check_prime(rsp_tdata, rsp_tuser);
         stall_left <= $urandom_range(0, stall_max);
      end
      result_waiting <= !reset && rsp_tvalid && !rsp_tready;
   end

   // Receiver: the stall only counts down while a prime is waiting, so it lands on the output.
   always @(negedge clock) begin
      if (reset || hold_results) begin
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         if (result_waiting)
            stall_left <= stall_left - 1;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Sends one candidate after a random gap and predicts it when accepted.
   // The valid stays high on return so that back-to-back requests never drop it.
   task automatic send_candidate(input logic [VBITS-1:0] cand);
      int unsigned gap;
      gap = $urandom_range(0, gap_max);
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= DATA_W'(cand);
      do @(posedge clock); while (!req_tready);
      predict_candidate(cand);
      requests_sent++;
   endtask

   task automatic send_next_count;
      send_candidate(VBITS'(next_count));
      next_count++;
   endtask

   // Extremes, values below two, repeats and out-of-order candidates.
   task automatic test_directed;
      gap_max   = 15;
      stall_max = 15;
      send_candidate(0);
      send_candidate(1);
      send_candidate(2);
      send_candidate(3);
      send_candidate(2);
      send_candidate(4);
      send_candidate(5);
      send_candidate(1);
      send_candidate(0);
      send_candidate(16'hFFFF);
      send_candidate(65521);
      send_candidate(16'h8000);
      send_candidate(7);
      send_candidate(9);
      send_candidate(11);
      send_candidate(49);
      send_candidate(13);
      send_candidate(65521);
      send_candidate(16'h5555);
      send_candidate(16'hAAAA);
      send_candidate(17);
      send_candidate(10);
      next_count = 18;
   endtask

   // Plain ascending count with random idling; fills the table past its last entry.
   task automatic test_counting;
      gap_max   = 15;
      stall_max = 15;
      while (next_count <= 400)
         send_next_count();
   endtask

   // Output held off for a long stretch while requests keep coming, so the input stalls.
   task automatic test_backpressure;
      gap_max   = 0;
      stall_max = 0;
      fork
         begin
            @(posedge clock);
            hold_results = 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_results = 1'b0;
         end
         begin
            while (next_count <= 460)
               send_next_count();
         end
      join
   endtask

   // Full rate on both sides.
   task automatic test_no_idle;
      gap_max   = 0;
      stall_max = 0;
      while (next_count <= 640)
         send_next_count();
   endtask

   // Mostly the ascending count with occasional skips, mixed with noise,
   // repeats and values below two; idling changes every hundred requests.
   task automatic test_random_mix;
      int unsigned      n;
      int unsigned      pick;
      logic [VBITS-1:0] cand;
      logic [VBITS-1:0] last_cand;
      last_cand = VBITS'(next_count);
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 100 == 0) begin
            case ($urandom_range(0, 2))
               0: gap_max = 0;
               1: gap_max = 3;
               default: gap_max = 15;
            endcase
            case ($urandom_range(0, 2))
               0: stall_max = 0;
               1: stall_max = 3;
               default: stall_max = 15;
            endcase
         end
         pick = $urandom_range(0, 99);
         if (pick < 80) begin
            if (pick < 5)
               next_count += $urandom_range(1, 40);
            cand = VBITS'(next_count);
            next_count++;
         end else if (pick < 90) begin
            cand = VBITS'($urandom);
         end else if (pick < 95) begin
            cand = last_cand;
         end else begin
            cand = VBITS'($urandom_range(0, 1));
         end
         send_candidate(cand);
         last_cand = cand;
      end
   endtask

   // Drops the request valid and waits for every pending prime, then a little longer.
   task automatic drain_results;
      int unsigned waited;
      waited = 0;
      @(negedge clock);
      req_tvalid <= 1'b0;
      stall_max = 0;
      while (expected_primes.size() > 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (3 * BLOCK_CYCLES) @(posedge clock);
   endtask

   // Test sequence.
   initial begin
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_counting();
      test_backpressure();
      test_no_idle();
      test_random_mix();
      drain_results();
      if (expected_primes.size() != 0)
         note_failure($sformatf("%0d expected primes never arrived", expected_primes.size()));
      $display("Sent %0d candidates; checked %0d primes, %0d stored and %0d past a full table.",
               requests_sent, primes_checked, stored_checked, primes_checked - stored_checked);
      $display("Covered values below two, repeats, a %0d-cycle output hold; %0d failures.",
               HOLD_CYCLES, failures);
      if (failures == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// File: prime_sieve_filter.f
design/psf_pkg.sv
design/psf_cell.sv
design/psf_ctrl.sv
design/prime_sieve_filter.sv
tb/tb.sv
